// ----- hw/rtl/cmsd_pkg.sv -----
// package for the column mean and standard deviation block
// widths, job and queue status types, column decode helper
// no dependencies
package cmsd_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COL_W       = 3;
  localparam int MAX_COLUMNS = 8;
  localparam int CFG_W       = 4;
  localparam int SUM_W       = 32;
  localparam int SQ_W        = 48;
  localparam int SQUARE_W    = 2 * SAMPLE_W;
  localparam int CNT_W       = 17;
  localparam int QHALF_W     = SQ_W / 2;
  localparam int QMAX_SHIFT  = 2 * (SAMPLE_W - 1);
  localparam int RAD_W       = 64;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int DIV_W       = 32;
  localparam int STEP_W      = 5;
  localparam int STAT_W      = 16;

  localparam logic [CNT_W-1:0] MAX_ROWS = CNT_W'(65536);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // apb side
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_COLUMNS_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] COLUMNS_RESET = CFG_W'(1);

  // one column's totals handed from front to back
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [CNT_W-1:0] n;
    logic             last;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

  // index of the final column in use, register clamped to 1..MAX_COLUMNS
  function automatic logic [COL_W-1:0] last_column(input logic [CFG_W-1:0] cfg);
    if (cfg == '0) begin
      return '0;
    end else if (cfg > CFG_W'(MAX_COLUMNS)) begin
      return COL_W'(MAX_COLUMNS - 1);
    end else begin
      return COL_W'(cfg - 1'b1);
    end
  endfunction

endpackage

// ----- hw/rtl/cmsd_channels.sv -----
// valid/ready channel interfaces for samples in and statistics out
// depends on cmsd_pkg
interface cmsd_sample_if;
  import cmsd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [COL_W-1:0]           column;
  logic                       end_of_set;

  modport source (output valid, sample, column, end_of_set, input ready);
  modport sink (input valid, sample, column, end_of_set, output ready);
endinterface

interface cmsd_result_if;
  import cmsd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [COL_W-1:0]         result_column;
  logic signed [STAT_W-1:0] mean;
  logic [STAT_W-1:0]        std_deviation;
  logic                     empty_set;
  logic                     last_result;

  modport source (output valid, result_column, mean, std_deviation, empty_set, last_result,
                  input ready);
  modport sink (input valid, result_column, mean, std_deviation, empty_set, last_result,
                output ready);
endinterface

// ----- hw/rtl/cmsd_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
// depends on cmsd_pkg
module cmsd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cmsd_pkg::DIV_W-1:0]  dividend,
  input  logic [cmsd_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [cmsd_pkg::DIV_W-1:0]  quotient
);
  import cmsd_pkg::*;

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   dvs;
  logic [CNT_W-1:0]   rem;
  logic [DIV_W-1:0]   quo;
  logic [CNT_W:0]     rem_sh;
  logic               fits;

  assign rem_sh   = {rem, quo[DIV_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= CNT_W'(rem_sh - {1'b0, dvs});
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CNT_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- hw/rtl/cmsd_queue.sv -----
// short job queue between the accumulating front and the arithmetic back
// depends on cmsd_pkg
module cmsd_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  cmsd_pkg::job_t           push_job,
  input  logic                     pop,
  output cmsd_pkg::job_t           head,
  output cmsd_pkg::queue_status_t  stat
);
  import cmsd_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   fill;

  assign head           = slots[rptr];
  assign stat.full      = fill == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign stat.not_empty = fill != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

endmodule

// ----- hw/rtl/cmsd_front.sv -----
// front end: takes samples, keeps per-column sums and row count,
// hands one job per column to the queue at end of set; depends on cmsd_pkg, cmsd_channels
module cmsd_front (
  input  logic                     clk,
  input  logic                     rst,
  cmsd_sample_if.sink              samples,
  input  logic [cmsd_pkg::COL_W-1:0] last_col,
  input  cmsd_pkg::queue_status_t  queue_stat,
  output logic                     push,
  output cmsd_pkg::job_t           job
);
  import cmsd_pkg::*;

  localparam logic FS_ACC   = 1'b0;
  localparam logic FS_DRAIN = 1'b1;

  logic                       state;
  logic [COL_W-1:0]           idx;

  // registered sample with its square
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic [COL_W-1:0]           s1_col;
  logic                       s1_last;
  logic [SQUARE_W-1:0]        s1_square;
  logic signed [SQUARE_W-1:0] square_w;

  logic [SUM_W-1:0]           sums [MAX_COLUMNS];
  logic [SQ_W-1:0]            sqs  [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0]     filled;
  logic [CNT_W-1:0]           row_count;

  logic [COL_W-1:0]           rd_addr;
  logic [SUM_W-1:0]           rd_sum;
  logic [SQ_W-1:0]            rd_sq;
  logic                       accept;
  logic                       use_sample;

  assign samples.ready = (state == FS_ACC) && !(s1_valid && s1_last);
  assign accept        = samples.valid && samples.ready;
  assign square_w      = samples.sample * samples.sample;

  // entries not written since the last clear read as zero
  assign rd_addr = (state == FS_DRAIN) ? idx : s1_col;
  assign rd_sum  = filled[rd_addr] ? sums[rd_addr] : '0;
  assign rd_sq   = filled[rd_addr] ? sqs[rd_addr] : '0;

  assign use_sample = (state == FS_ACC) && s1_valid && (s1_col <= last_col) &&
                      (row_count != MAX_ROWS);

  assign push     = (state == FS_DRAIN) && !queue_stat.full;
  assign job.col  = idx;
  assign job.sum  = rd_sum;
  assign job.sq   = rd_sq;
  assign job.n    = row_count;
  assign job.last = idx == last_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FS_ACC;
      idx       <= '0;
      s1_valid  <= 1'b0;
      filled    <= '0;
      row_count <= '0;
    end else begin
      s1_valid <= accept;
      if (use_sample) begin
        filled[s1_col] <= 1'b1;
        if (s1_col == last_col) begin
          row_count <= row_count + 1'b1;
        end
      end
      unique case (state)
        FS_ACC: begin
          if (s1_valid && s1_last) begin
            state <= FS_DRAIN;
            idx   <= '0;
          end
        end
        FS_DRAIN: begin
          if (push) begin
            if (idx == last_col) begin
              filled    <= '0;
              row_count <= '0;
              state     <= FS_ACC;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= samples.sample;
      s1_col    <= samples.column;
      s1_last   <= samples.end_of_set;
      s1_square <= square_w;
    end
    if (use_sample) begin
      sums[s1_col] <= rd_sum + SUM_W'(s1_sample);
      sqs[s1_col]  <= rd_sq + SQ_W'(s1_square);
    end
  end

endmodule

// ----- hw/rtl/cmsd_back.sv -----
// back end: per column job computes mean and population std deviation
// with split multiplies, a bit-serial square root and a shared divider
// depends on cmsd_pkg, cmsd_channels, cmsd_div
module cmsd_back (
  input  logic                     clk,
  input  logic                     rst,
  input  cmsd_pkg::job_t           job,
  input  cmsd_pkg::queue_status_t  queue_stat,
  output logic                     pop,
  cmsd_result_if.source            results
);
  import cmsd_pkg::*;

  localparam logic [3:0] BS_IDLE = 4'd0;
  localparam logic [3:0] BS_MLO  = 4'd1;
  localparam logic [3:0] BS_MHI  = 4'd2;
  localparam logic [3:0] BS_SQ   = 4'd3;
  localparam logic [3:0] BS_SUB  = 4'd4;
  localparam logic [3:0] BS_ROOT = 4'd5;
  localparam logic [3:0] BS_DMGO = 4'd6;
  localparam logic [3:0] BS_DMW  = 4'd7;
  localparam logic [3:0] BS_DSGO = 4'd8;
  localparam logic [3:0] BS_DSW  = 4'd9;
  localparam logic [3:0] BS_EMIT = 4'd10;

  localparam logic [DIV_W-1:0]  MEAN_POS_LIMIT = DIV_W'(32767);
  localparam logic [DIV_W-1:0]  MEAN_NEG_LIMIT = DIV_W'(32768);
  localparam logic [STAT_W-1:0] MEAN_POS_SAT   = STAT_W'(32767);
  localparam logic [STAT_W-1:0] MEAN_NEG_SAT   = STAT_W'(32768);

  logic [3:0]              state;

  // latched job
  logic [COL_W-1:0]        col_r;
  logic                    last_r;
  logic                    empty_r;
  logic                    neg_r;
  logic [SUM_W-1:0]        abs_s;
  logic [SQ_W-1:0]         q_c;
  logic [CNT_W-1:0]        n_r;

  // n*q - s*s
  logic [QHALF_W-1:0]         q_part;
  logic [CNT_W+QHALF_W-1:0]   mult_prod;
  logic [CNT_W+QHALF_W-1:0]   pr;
  logic [RAD_W-1:0]           nq;
  logic [RAD_W-1:0]           ss;
  logic [RAD_W-1:0]           sq_prod;
  logic [RAD_W:0]             diff;

  // square root
  logic [RAD_W-1:0]        rad;
  logic [ROOT_W+1:0]       rem;
  logic [ROOT_W-1:0]       root;
  logic [STEP_W-1:0]       step;
  logic [ROOT_W+3:0]       rem_sh;
  logic [ROOT_W+3:0]       trial;

  // divider
  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic                    div_done;
  logic [DIV_W-1:0]        div_quotient;

  // job decode
  logic [SQ_W-1:0]         qmax;
  logic [SUM_W-1:0]        job_abs;

  logic [STAT_W-1:0]       mean_r;
  logic [STAT_W-1:0]       sd_r;
  logic                    out_valid;
  logic                    out_load;

  // output register, holds a result while the next column is worked on
  logic [COL_W-1:0]        out_col;
  logic [STAT_W-1:0]       out_mean;
  logic [STAT_W-1:0]       out_sd;
  logic                    out_empty;
  logic                    out_last;

  assign qmax    = SQ_W'({job.n, {QMAX_SHIFT{1'b0}}});
  assign job_abs = job.sum[SUM_W-1] ? SUM_W'(-job.sum) : job.sum;
  assign pop     = (state == BS_IDLE) && queue_stat.not_empty;

  assign q_part    = (state == BS_MLO) ? q_c[QHALF_W-1:0] : q_c[SQ_W-1:QHALF_W];
  assign mult_prod = n_r * q_part;
  assign sq_prod   = abs_s * abs_s;
  assign diff      = {1'b0, nq} - {1'b0, ss};

  assign rem_sh = {rem, rad[RAD_W-1:RAD_W-2]};
  assign trial  = {2'b00, root, 2'b01};

  assign div_start    = (state == BS_DMGO) || (state == BS_DSGO);
  assign div_dividend = (state == BS_DMGO) ? abs_s : root;

  cmsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign out_load = (state == BS_EMIT) && (!out_valid || results.ready);

  assign results.valid         = out_valid;
  assign results.result_column = out_col;
  assign results.mean          = $signed(out_mean);
  assign results.std_deviation = out_sd;
  assign results.empty_set     = out_empty;
  assign results.last_result   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        BS_IDLE: begin
          if (pop) begin
            state <= (job.n == '0) ? BS_EMIT : BS_MLO;
          end
        end
        BS_MLO:  state <= BS_MHI;
        BS_MHI:  state <= BS_SQ;
        BS_SQ:   state <= BS_SUB;
        BS_SUB: begin
          state <= BS_ROOT;
          step  <= '0;
        end
        BS_ROOT: begin
          if (step == STEP_W'(ROOT_W - 1)) begin
            state <= BS_DMGO;
          end else begin
            step <= step + 1'b1;
          end
        end
        BS_DMGO: state <= BS_DMW;
        BS_DMW: begin
          if (div_done) begin
            state <= BS_DSGO;
          end
        end
        BS_DSGO: state <= BS_DSW;
        BS_DSW: begin
          if (div_done) begin
            state <= BS_EMIT;
          end
        end
        BS_EMIT: begin
          if (out_load) begin
            state <= BS_IDLE;
          end
        end
        default: state <= BS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_col   <= col_r;
      out_mean  <= mean_r;
      out_sd    <= sd_r;
      out_empty <= empty_r;
      out_last  <= last_r;
    end
    unique case (state)
      BS_IDLE: begin
        if (pop) begin
          col_r   <= job.col;
          last_r  <= job.last;
          empty_r <= job.n == '0;
          neg_r   <= job.sum[SUM_W-1];
          abs_s   <= job_abs;
          q_c     <= (job.sq > qmax) ? qmax : job.sq;
          n_r     <= job.n;
          mean_r  <= '0;
          sd_r    <= '0;
        end
      end
      BS_MLO: pr <= mult_prod;
      BS_MHI: begin
        nq <= RAD_W'(pr);
        pr <= mult_prod;
      end
      BS_SQ: begin
        nq <= nq + (RAD_W'(pr) << QHALF_W);
        ss <= sq_prod;
      end
      BS_SUB: begin
        // inconsistent totals give a negative spread, taken as zero
        rad  <= diff[RAD_W] ? '0 : diff[RAD_W-1:0];
        rem  <= '0;
        root <= '0;
      end
      BS_ROOT: begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= (ROOT_W + 2)'(rem_sh - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[ROOT_W+1:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end
      BS_DMW: begin
        if (div_done) begin
          if (!neg_r) begin
            mean_r <= (div_quotient > MEAN_POS_LIMIT) ? MEAN_POS_SAT : div_quotient[STAT_W-1:0];
          end else begin
            mean_r <= (div_quotient > MEAN_NEG_LIMIT) ? MEAN_NEG_SAT :
                      STAT_W'(-div_quotient[STAT_W-1:0]);
          end
        end
      end
      BS_DSW: begin
        if (div_done) begin
          sd_r <= (|div_quotient[DIV_W-1:STAT_W]) ? '1 : div_quotient[STAT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/column_mean_and_std_deviation.sv -----
// top level: column mean and population standard deviation over a data set
// depends on cmsd_pkg, cmsd_channels, cmsd_front, cmsd_queue, cmsd_back
//
// channel   | dir | handshake          | payload
// ----------+-----+--------------------+------------------------------------------------
// samples   | in  | valid/ready        | sample, column, end_of_set
// results   | out | valid/ready        | result_column, mean, std_deviation, empty_set,
//           |     |                    | last_result
// apb       | in  | psel/penable/pready| paddr, pwdata, prdata (columns_in_use at 0)
//
// the front takes one sample transfer per cycle while it accumulates; an end_of_set
// transfer holds off input while it is folded in and while the totals of each column in
// use are queued one column at a time, longer while the queue is full
// the back works on one column at a time: it takes the job, forms the split products and
// the subtraction, runs the bit-serial square root, makes the two passes of the shared
// divider and hands the result to the output register
// reset (rst, synchronous) empties the queue, clears the totals and sets one column
// either side may stall: the four-deep queue and the output register decouple them
module column_mean_and_std_deviation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cmsd_pkg::ADDR_W-1:0]   paddr,
  input  logic [cmsd_pkg::DATA_W-1:0]   pwdata,
  output logic [cmsd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  cmsd_sample_if.sink                   samples,
  cmsd_result_if.source                 results
);
  import cmsd_pkg::*;

  logic [CFG_W-1:0]  columns_in_use;
  logic [COL_W-1:0]  last_col;
  logic              reg_sel;
  logic              reg_write;

  job_t              push_job;
  job_t              head_job;
  logic              job_push;
  logic              job_pop;
  queue_status_t     queue_stat;

  // register map: word index from paddr[2], only columns_in_use exists
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2] == REG_COLUMNS_IN_USE;
  assign reg_write = psel && penable && pwrite && pready && reg_sel;
  assign prdata    = reg_sel ? DATA_W'(columns_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= COLUMNS_RESET;
    end else if (reg_write) begin
      columns_in_use <= pwdata[CFG_W-1:0];
    end
  end

  // zero acts as one column, anything past the table as all columns
  assign last_col = last_column(columns_in_use);

  // accumulate samples, queue column totals at the end of a set
  cmsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .last_col   (last_col),
    .queue_stat (queue_stat),
    .push       (job_push),
    .job        (push_job)
  );

  cmsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head     (head_job),
    .stat     (queue_stat)
  );

  // per-column arithmetic and the output register
  cmsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job        (head_job),
    .queue_stat (queue_stat),
    .pop        (job_pop),
    .results    (results)
  );

  // the front never writes into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !queue_stat.full)
    else $error("job queued while the queue is full");

  // the back only takes a job that is there
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> queue_stat.not_empty)
    else $error("job taken from an empty queue");

  // an empty set reports zero statistics
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.empty_set |-> results.mean == '0 && results.std_deviation == '0)
    else $error("empty set result carries nonzero statistics");

  // a set's last result goes out before the next set's first column
  a_column_order: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && results.last_result |=>
      !results.valid || results.result_column == '0)
    else $error("result after the final column does not restart at column zero");

endmodule
